FILE: rtl/tclfu_pkg.sv
// Shared constants and types for the two-way cache tag lookup with LFU replacement.
// Used by tclfu_tag_store and two_way_cache_tag_lookup_lfu; depends on nothing.
`default_nettype none

package tclfu_pkg;

    // Cache geometry
    localparam int SET_COUNT    = 4;
    localparam int LINE_BYTES   = 8;
    localparam int ADDRESS_BITS = 16;
    localparam int COUNT_BITS   = 8;
    localparam int WAYS         = 2;

    localparam int OFFSET_BITS = $clog2(LINE_BYTES);
    localparam int SET_BITS    = $clog2(SET_COUNT);
    localparam int TAG_BITS    = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
    localparam int WAY_BITS    = 1;

    // Fixed result field widths
    localparam int SET_FIELD_BITS   = 2;
    localparam int TOTAL_BITS       = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef logic [SET_BITS-1:0]     set_idx_t;
    typedef logic [TAG_BITS-1:0]     tag_t;
    typedef logic [COUNT_BITS-1:0]   use_count_t;
    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [TOTAL_BITS-1:0]   total_t;

    // Lookup outcome from the tag store
    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
    } lookup_t;

endpackage

`default_nettype wire

FILE: rtl/tclfu_tag_store.sv
// Per-set tag, valid and use-count store with combinational lookup and registered update on commit.
// Depends on tclfu_pkg.
`default_nettype none

module tclfu_tag_store (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       commit,
    input  wire  tclfu_pkg::set_idx_t set_idx,
    input  wire  tclfu_pkg::tag_t     tag,
    output tclfu_pkg::lookup_t        lookup
);
    import tclfu_pkg::*;

    logic       valid_reg [SET_COUNT][WAYS];
    tag_t       tag_reg   [SET_COUNT][WAYS];
    use_count_t count_reg [SET_COUNT][WAYS];

    logic       hit0;
    logic       hit1;
    use_count_t count0;
    use_count_t count1;
    use_count_t count_sel;

    // Compare both ways of the selected set; way 0 wins when both match
    always_comb
    begin
        count0 = count_reg[set_idx][0];
        count1 = count_reg[set_idx][1];
        hit0   = valid_reg[set_idx][0] && (tag_reg[set_idx][0] == tag);
        hit1   = valid_reg[set_idx][1] && (tag_reg[set_idx][1] == tag);
        lookup.hit = hit0 || hit1;
        if (hit0)
        begin
            lookup.way = 1'b0;
        end
        else if (hit1)
        begin
            lookup.way = 1'b1;
        end
        else
        begin
            // victim: strictly smaller count, tie to way 0
            lookup.way = (count1 < count0) ? 1'b1 : 1'b0;
        end
        count_sel = lookup.way ? count1 : count0;
    end

    // Valid bits and use counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SET_COUNT; s++)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    valid_reg[s][w] <= 1'b0;
                    count_reg[s][w] <= '0;
                end
            end
        end
        else if (commit)
        begin
            if (lookup.hit)
            begin
                if (count_sel != COUNT_MAX)
                begin
                    count_reg[set_idx][lookup.way] <= count_sel + COUNT_ONE;
                end
            end
            else
            begin
                valid_reg[set_idx][lookup.way] <= 1'b1;
                count_reg[set_idx][lookup.way] <= COUNT_ONE;
            end
        end
    end

    // Tags: written on a fill only
    always_ff @(posedge clk)
    begin
        if (commit && !lookup.hit)
        begin
            tag_reg[set_idx][lookup.way] <= tag;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/two_way_cache_tag_lookup_lfu.sv
// Top level of the two-way cache tag lookup with LFU replacement.
// Depends on tclfu_pkg and tclfu_tag_store.
//
// Looks up one byte address per request against a 4-set, 2-way tag store with
// 8-byte lines and least-frequently-used replacement. A request is taken into an
// input register. Once the output register is free or emptying, it is checked
// and committed to the tag store, and its result lands in an output register.
// One request can be accepted every cycle while results are taken: the tag
// store reads and updates a set in the same cycle, which sets that rate, and a
// later request always sees the updates of the one before it. A held result
// stalls the input register, and in_ready drops until the result is taken.
// Hit and miss totals count from reset and wrap at 16 bits; each result shows the
// totals including itself.
`default_nettype none

module two_way_cache_tag_lookup_lfu (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire  tclfu_pkg::addr_t byte_address,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic                   was_hit,
    output logic [1:0]             set_number,
    output logic                   way_used,
    output tclfu_pkg::total_t      total_hits,
    output tclfu_pkg::total_t      total_misses
);
    import tclfu_pkg::*;

    logic     req_valid_reg;
    addr_t    req_addr_reg;
    logic     out_valid_reg;
    logic     hit_reg;
    logic [SET_FIELD_BITS-1:0] set_reg;
    logic     way_reg;
    total_t   hit_total_reg;
    total_t   miss_total_reg;
    total_t   hit_total_next;
    total_t   miss_total_next;

    logic     advance;
    set_idx_t set_idx;
    tag_t     tag;
    lookup_t  lookup;

    // Handshake: the stage moves when the output register is free or emptying
    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    // Address split
    assign set_idx = req_addr_reg[OFFSET_BITS +: SET_BITS];
    assign tag     = req_addr_reg[ADDRESS_BITS-1 -: TAG_BITS];

    tclfu_tag_store u_tag_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .commit  (advance),
        .set_idx (set_idx),
        .tag     (tag),
        .lookup  (lookup)
    );

    // Running totals
    always_comb
    begin
        hit_total_next  = hit_total_reg;
        miss_total_next = miss_total_reg;
        if (advance)
        begin
            if (lookup.hit)
            begin
                hit_total_next = hit_total_reg + TOTAL_BITS'(1);
            end
            else
            begin
                miss_total_next = miss_total_reg + TOTAL_BITS'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            hit_total_reg  <= hit_total_next;
            miss_total_reg <= miss_total_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_addr_reg <= byte_address;
        end
        if (advance)
        begin
            hit_reg <= lookup.hit;
            set_reg <= SET_FIELD_BITS'(set_idx);
            way_reg <= lookup.way;
        end
    end

    assign out_valid    = out_valid_reg;
    assign was_hit      = hit_reg;
    assign set_number   = set_reg;
    assign way_used     = way_reg;
    assign total_hits   = hit_total_reg;
    assign total_misses = miss_total_reg;

    // Each committed lookup adds exactly one to hits plus misses
    total_t total_sum;
    assign total_sum = hit_total_reg + miss_total_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> total_sum == $past(total_sum) + TOTAL_BITS'(1))
        else $error("hit plus miss total did not step by one");

    // Totals move only when a lookup commits
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(hit_total_reg) && $stable(miss_total_reg))
        else $error("totals changed without a committed lookup");

    // An empty output register never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

    // A committed lookup always yields a result the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("committed lookup produced no result");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for two_way_cache_tag_lookup_lfu: drives byte-address requests,
// predicts hit, set, way and running totals of the 2-way LFU tag store, checks every result.
// Depends on tclfu_pkg and the RTL of two_way_cache_tag_lookup_lfu.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tclfu_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_LIMIT  = 5_000;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOT_HITS     = 260;
    localparam int POOL_DEPTH   = 3;
    localparam int STREAM_ITEMS = 30;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    // One expected lookup result, in port order
    typedef struct packed {
        logic     hit;
        set_idx_t set_num;
        logic     way;
        total_t   hits;
        total_t   misses;
    } lookup_result_t;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   in_valid     = 1'b0;
    addr_t  byte_address = '0;
    logic   out_ready    = 1'b0;
    logic   in_ready;
    logic   out_valid;
    logic   was_hit;
    logic [1:0] set_number;
    logic   way_used;
    total_t total_hits;
    total_t total_misses;

    // Tag store mirror
    bit         line_valid [SET_COUNT][WAYS];
    tag_t       line_tag   [SET_COUNT][WAYS];
    use_count_t line_uses  [SET_COUNT][WAYS];
    total_t     pred_hits   = '0;
    total_t     pred_misses = '0;

    lookup_result_t expected_lookups[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  quiet_traffic = 1'b0;

    two_way_cache_tag_lookup_lfu u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .was_hit      (was_hit),
        .set_number   (set_number),
        .way_used     (way_used),
        .total_hits   (total_hits),
        .total_misses (total_misses)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle cycles before the next request or the next ready; none in quiet stretches
    function automatic int draw_idle();
        return quiet_traffic ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic addr_t make_address(tag_t t, set_idx_t s, offset_t off);
        return {t, s, off};
    endfunction

    // Lookup and update of the mirrored tag store for one accepted request
    function automatic lookup_result_t predict_lookup(addr_t a);
        lookup_result_t r;
        set_idx_t s;
        tag_t t;
        s = a[OFFSET_BITS +: SET_BITS];
        t = a[ADDRESS_BITS-1 -: TAG_BITS];
        r = '0;
        // way 0 is searched first, only valid ways match
        for (int w = 0; w < WAYS; w++)
        begin
            if (!r.hit && line_valid[s][w] && line_tag[s][w] == t)
            begin
                r.hit = 1'b1;
                r.way = w[0];
            end
        end
        if (r.hit)
        begin
            if (line_uses[s][r.way] != COUNT_MAX)
                line_uses[s][r.way] = line_uses[s][r.way] + 1'b1;
            pred_hits = pred_hits + 1'b1;
        end
        else
        begin
            // smaller count loses, tie goes to way 0
            r.way = (line_uses[s][1] < line_uses[s][0]);
            line_valid[s][r.way] = 1'b1;
            line_tag[s][r.way]   = t;
            line_uses[s][r.way]  = COUNT_ONE;
            pred_misses = pred_misses + 1'b1;
        end
        r.set_num = s;
        r.hits    = pred_hits;
        r.misses  = pred_misses;
        return r;
    endfunction

    // Send one request; valid is left high so a back-to-back request keeps it up
    task automatic send_request(input addr_t a);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        byte_address <= a;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        expected_lookups.push_back(predict_lookup(a));
    endtask

    // Result checker with random back-pressure
    initial
    begin
        int stall;
        lookup_result_t want;
        forever
        begin
            stall = draw_idle();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            if (expected_lookups.size() == 0)
            begin
                $error("result with no request waiting");
                error_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (was_hit !== want.hit)
                begin
                    $error("was_hit: expected %0d, actual %0d", want.hit, was_hit);
                    error_count++;
                end
                if (set_number !== want.set_num)
                begin
                    $error("set_number: expected %0d, actual %0d", want.set_num, set_number);
                    error_count++;
                end
                if (way_used !== want.way)
                begin
                    $error("way_used: expected %0d, actual %0d", want.way, way_used);
                    error_count++;
                end
                if (total_hits !== want.hits)
                begin
                    $error("total_hits: expected %0d, actual %0d", want.hits, total_hits);
                    error_count++;
                end
                if (total_misses !== want.misses)
                begin
                    $error("total_misses: expected %0d, actual %0d",
                           want.misses, total_misses);
                    error_count++;
                end
            end
        end
    end

    // Fresh sets fill way 0 then way 1; an unfilled way never hits
    task automatic test_fresh_set_fill();
        send_request(make_address(11'd0, 2'd0, 3'd0));
        send_request(make_address(11'd1, 2'd0, 3'd0));
        send_request(make_address(11'd0, 2'd0, 3'd7));
        send_request(make_address(11'd1, 2'd0, 3'd7));
        // tag zero against a never-written way
        send_request(make_address(11'd0, 2'd2, 3'd0));
    endtask

    // Victim is the way with the lower use count; equal counts pick way 0
    task automatic test_lfu_victim_choice();
        send_request(make_address(11'd5, 2'd1, 3'd0));
        send_request(make_address(11'd6, 2'd1, 3'd1));
        send_request(make_address(11'd5, 2'd1, 3'd2));
        send_request(make_address(11'd5, 2'd1, 3'd3));
        send_request(make_address(11'd7, 2'd1, 3'd4));
        repeat (3) send_request(make_address(11'd7, 2'd1, 3'd5));
        send_request(make_address(11'd8, 2'd1, 3'd6));
        // tie in a fresh set
        send_request(make_address(11'd1, 2'd3, 3'd0));
        send_request(make_address(11'd2, 2'd3, 3'd0));
        send_request(make_address(11'd3, 2'd3, 3'd0));
    endtask

    task automatic test_address_extremes();
        send_request(16'hFFFF);
        send_request(16'hFFF8);
        send_request(16'h0000);
        send_request(16'h7FFF);
        send_request(16'h8000);
    endtask

    // Drive two ways of one set past the count ceiling, then force a tie on the next miss
    task automatic test_count_saturation();
        tag_t first_tag;
        first_tag = tag_t'($urandom_range(16, 2047)) & ~tag_t'(3);
        repeat (HOT_HITS + 1)
            send_request(make_address(first_tag, 2'd2, offset_t'($urandom)));
        repeat (HOT_HITS + 1)
            send_request(make_address(first_tag | 1'b1, 2'd2, offset_t'($urandom)));
        send_request(make_address(first_tag | 2'd2, 2'd2, offset_t'($urandom)));
    endtask

    // Mostly a small working set per set, with evictions, noise and repeats
    task automatic test_random_traffic();
        tag_t  pool [SET_COUNT][POOL_DEPTH];
        addr_t last_addr;
        int    pick;
        int    slot;
        set_idx_t s;
        last_addr = '0;
        for (int i = 0; i < SET_COUNT; i++)
            for (int k = 0; k < POOL_DEPTH; k++)
                pool[i][k] = tag_t'($urandom);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 49) == 0)
                quiet_traffic = !quiet_traffic;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                last_addr = addr_t'($urandom_range(0, 65535));
            else if (pick < 90)
            begin
                s    = set_idx_t'($urandom);
                slot = $urandom_range(0, POOL_DEPTH - 1);
                if (pick < 20)
                    pool[s][slot] = tag_t'($urandom);
                last_addr = make_address(pool[s][slot], s, offset_t'($urandom));
            end
            send_request(last_addr);
        end
        quiet_traffic = 1'b0;
    endtask

    // Back-to-back streams of hits on one line and of misses on fresh tags
    task automatic test_back_to_back_streams();
        addr_t  hot_addr;
        tag_t   next_tag;
        quiet_traffic = 1'b1;
        hot_addr = make_address(tag_t'($urandom), 2'd0, 3'd0);
        repeat (STREAM_ITEMS)
            send_request(hot_addr | addr_t'($urandom_range(0, 7)));
        // new tags in set 1 mostly miss
        next_tag = tag_t'($urandom);
        repeat (STREAM_ITEMS)
        begin
            send_request(make_address(next_tag, 2'd1, offset_t'($urandom)));
            next_tag = next_tag + 1'b1;
        end
        quiet_traffic = 1'b0;
    endtask

    // Sequence
    initial
    begin
        int drain_cycles;
        drain_cycles = 0;
        for (int i = 0; i < SET_COUNT; i++)
            for (int w = 0; w < WAYS; w++)
            begin
                line_valid[i][w] = 1'b0;
                line_tag[i][w]   = '0;
                line_uses[i][w]  = '0;
            end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_fresh_set_fill();
        test_lfu_victim_choice();
        test_address_extremes();
        test_count_saturation();
        test_random_traffic();
        test_back_to_back_streams();
        in_valid <= 1'b0;

        // wait for outstanding results, then settle to catch strays
        while (expected_lookups.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_lookups.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_lookups.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
